/* design/hts_pkg.sv */
// ----------------------------------------------------------------------------
// Heightfield sampler package
// Shared sizes, codes and word types of the heightfield triangle sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

    // Largest number of cells along one axis; the store holds one more point.
    localparam int GRID_MAX   = 64;
    localparam int STRIDE     = GRID_MAX + 1;
    localparam int MEM_DEPTH  = STRIDE * STRIDE;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // Bits of a cell index, wide enough to hold GRID_MAX itself.
    localparam int CELL_W     = $clog2(GRID_MAX + 1);

    // Field widths of the words and registers.
    localparam int COORD_W    = 7;
    localparam int HEIGHT_W   = 16;
    localparam int POS_W      = 24;
    localparam int IVL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_INTERVAL = 2'd2;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic [COORD_W-1:0]         grid_col;
        logic [COORD_W-1:0]         grid_row;
        logic signed [HEIGHT_W-1:0] height_value;
        logic [POS_W-1:0]           pos_x;
        logic [POS_W-1:0]           pos_z;
    } hts_in_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_out;
        logic                       outside;
    } hts_out_t;

endpackage

`default_nettype wire

/* design/heightfield_triangle_sampler.sv */
// ----------------------------------------------------------------------------
// Heightfield triangle sampler
// Grid of vertex heights with a sequenced triangle-plane height query.
// ----------------------------------------------------------------------------
// A write word stores one signed Q8.8 height at a grid point and gives no
// result. A query word takes an x,z position in Q16.8 world units and
// returns one result word. A query outside the grid in x is caught by the
// first range check and goes straight to the hand-over; one outside in z
// is caught by the second range check. A query inside the grid passes from
// acceptance to the output register through two range checks on the
// shared multiplier, two 7-step divisions for the cell indexes, the read
// states S_RD0 to S_RD3 that fetch three corner heights through the single
// read port of the height store, a multiply-accumulate in S_MUL0 and
// S_MUL1, a set-up state, a 19-step division by the doubled cell interval
// for the rounded plane height, and a hand-over state. All divisions run
// one quotient bit per cycle on one shared restoring divider. The input is
// stalled while a query is in progress, so the next query is accepted only
// after the last one has handed over its result; a finished result waits
// in the output register, and the next word is accepted meanwhile. A query
// whose result finds the output register still full waits and stalls the
// input until it is taken. The height store has no reset; reading a point
// that was never written gives an undefined height.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_triangle_sampler
    import hts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire hts_in_t               in_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output hts_out_t                   out_word
);

    // The final division works on 2*num + I offset by (2I << H_SH), which
    // keeps the dividend non-negative; |2*num + I| stays below 2I << 17.
    localparam int H_SH   = 18;
    localparam int QUOT_W = H_SH + 1;
    localparam int REM_W  = 36;
    localparam int CNT_W  = $clog2(QUOT_W);
    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = 21;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHKX,
        S_CHKZ,
        S_DIVX,
        S_DIVZ,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MUL0,
        S_MUL1,
        S_PREP,
        S_DIVH,
        S_FIN
    } state_t;

    // Registers.
    state_t                     state_reg,      state_next;
    logic [COORD_W-1:0]         width_reg,      width_next;
    logic [COORD_W-1:0]         depth_reg,      depth_next;
    logic [IVL_W-1:0]           ivl_reg,        ivl_next;
    logic [POS_W-1:0]           px_reg,         px_next;
    logic [POS_W-1:0]           pz_reg,         pz_next;
    logic [CELL_W-1:0]          cx_reg,         cx_next;
    logic [CELL_W-1:0]          cz_reg,         cz_next;
    logic [IVL_W-1:0]           fx_reg,         fx_next;
    logic [IVL_W-1:0]           fz_reg,         fz_next;
    logic                       lower_reg,      lower_next;
    logic signed [HEIGHT_W-1:0] h10_reg,        h10_next;
    logic signed [HEIGHT_W-1:0] h01_reg,        h01_next;
    logic signed [HEIGHT_W-1:0] base_reg,       base_next;
    logic signed [PROD_W-1:0]   num_reg,        num_next;
    logic [REM_W-1:0]           rem_reg,        rem_next;
    logic [REM_W-1:0]           dsh_reg,        dsh_next;
    logic [QUOT_W-1:0]          quot_reg,       quot_next;
    logic [CNT_W-1:0]           cnt_reg,        cnt_next;
    hts_out_t                   res_reg,        res_next;
    logic                       out_valid_reg,  out_valid_next;
    hts_out_t                   out_word_reg,   out_word_next;

    // Height store.
    logic signed [HEIGHT_W-1:0] mem [MEM_DEPTH];
    logic signed [HEIGHT_W-1:0] mem_q;
    logic                       mem_we;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;

    // Effective configuration.
    logic [CELL_W-1:0]          w_eff;
    logic [CELL_W-1:0]          d_eff;
    logic [IVL_W-1:0]           iv_eff;

    // Shared datapath.
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic                       div_ge;
    logic [REM_W-1:0]           rem_step;
    logic [QUOT_W-1:0]          quot_step;
    logic [IVL_W-1:0]           fa;
    logic [IVL_W-1:0]           fb;
    logic signed [HEIGHT_W:0]   diff_a;
    logic signed [HEIGHT_W:0]   diff_b;
    logic signed [PROD_W+1:0]   n_off;
    logic signed [SUM_W-1:0]    q_s;
    logic signed [SUM_W-1:0]    h_sum;
    logic signed [HEIGHT_W-1:0] h_sat;
    logic [CELL_W-1:0]          q_cell;
    logic                       in_accept;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CELL_W-1:0] row,
                                                  input logic [CELL_W-1:0] col);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(row) * ADDR_W'(STRIDE) + ADDR_W'(col);
        return a;
    endfunction

    // Out-of-range cell counts and a zero interval are pulled into range.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = CELL_W'(1);
        else if (CELL_W'(width_reg) > CELL_W'(GRID_MAX))
            w_eff = CELL_W'(GRID_MAX);
        else
            w_eff = CELL_W'(width_reg);

        if (depth_reg == '0)
            d_eff = CELL_W'(1);
        else if (CELL_W'(depth_reg) > CELL_W'(GRID_MAX))
            d_eff = CELL_W'(GRID_MAX);
        else
            d_eff = CELL_W'(depth_reg);

        iv_eff = (ivl_reg == '0) ? IVL_W'(1) : ivl_reg;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Store writes come straight from an accepted write word; points beyond
    // the grid limit are dropped.
    assign mem_we  = in_accept && (in_word.cmd == CMD_WRITE)
                     && (CELL_W'(in_word.grid_col) <= CELL_W'(GRID_MAX))
                     && (CELL_W'(in_word.grid_row) <= CELL_W'(GRID_MAX));
    assign wr_addr = addr_of(CELL_W'(in_word.grid_row), CELL_W'(in_word.grid_col));

    // Corner reads: h10, then h01, then the corner that anchors the triangle.
    always_comb
    begin
        case (state_reg)
            S_RD0:   rd_addr = addr_of(cz_reg, cx_reg + CELL_W'(1));
            S_RD1:   rd_addr = addr_of(cz_reg + CELL_W'(1), cx_reg);
            S_RD2:   rd_addr = lower_reg ? addr_of(cz_reg, cx_reg)
                                         : addr_of(cz_reg + CELL_W'(1),
                                                   cx_reg + CELL_W'(1));
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= in_word.height_value;
        end
        mem_q <= mem[rd_addr];
    end

    // Triangle weights: offsets for the lower triangle, complements above.
    // Above, h10 sits one interval back in z from the anchor, so its weight
    // is I - fz, and h01 sits one interval back in x, so its weight is I - fx.
    assign fa     = lower_reg ? fx_reg : iv_eff - fz_reg;
    assign fb     = lower_reg ? fz_reg : iv_eff - fx_reg;
    assign diff_a = $signed({h10_reg[HEIGHT_W-1], h10_reg})
                    - $signed({base_reg[HEIGHT_W-1], base_reg});
    assign diff_b = $signed({h01_reg[HEIGHT_W-1], h01_reg})
                    - $signed({base_reg[HEIGHT_W-1], base_reg});

    // The one multiplier, shared by the range checks and the plane sums.
    always_comb
    begin
        case (state_reg)
            S_CHKX:
            begin
                mul_a = $signed(MUL_W'(w_eff));
                mul_b = $signed(MUL_W'(iv_eff));
            end
            S_CHKZ:
            begin
                mul_a = $signed(MUL_W'(d_eff));
                mul_b = $signed(MUL_W'(iv_eff));
            end
            S_MUL0:
            begin
                mul_a = $signed({diff_a[HEIGHT_W], diff_a});
                mul_b = $signed(MUL_W'(fa));
            end
            S_MUL1:
            begin
                mul_a = $signed({diff_b[HEIGHT_W], diff_b});
                mul_b = $signed(MUL_W'(fb));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // One restoring division step: one quotient bit per cycle.
    assign div_ge    = (rem_reg >= dsh_reg);
    assign rem_step  = div_ge ? rem_reg - dsh_reg : rem_reg;
    assign quot_step = {quot_reg[QUOT_W-2:0], div_ge};
    assign q_cell    = quot_step[CELL_W-1:0];

    // Offset dividend: 2*num + I + (2I << H_SH), never negative.
    assign n_off = ($signed({{2{num_reg[PROD_W-1]}}, num_reg}) <<< 1)
                   + $signed((PROD_W+2)'(iv_eff))
                   + $signed((PROD_W+2)'(iv_eff) << (H_SH + 1));

    // Undo the offset, add the anchor height, saturate to Q8.8.
    assign q_s   = $signed(SUM_W'(quot_step)) - $signed(SUM_W'(1) << H_SH);
    assign h_sum = $signed({{(SUM_W-HEIGHT_W){base_reg[HEIGHT_W-1]}}, base_reg}) + q_s;

    always_comb
    begin
        if (h_sum > $signed(SUM_W'(32767)))
            h_sat = 16'sh7FFF;
        else if (h_sum < -$signed(SUM_W'(32768)))
            h_sat = -16'sh8000;
        else
            h_sat = h_sum[HEIGHT_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        depth_next     = depth_reg;
        ivl_next       = ivl_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        cx_next        = cx_reg;
        cz_next        = cz_reg;
        fx_next        = fx_reg;
        fz_next        = fz_reg;
        lower_next     = lower_reg;
        h10_next       = h10_reg;
        h01_next       = h01_reg;
        base_next      = base_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:    width_next = cfg_data[COORD_W-1:0];
                REG_GRID_DEPTH:    depth_next = cfg_data[COORD_W-1:0];
                REG_CELL_INTERVAL: ivl_next   = cfg_data[IVL_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_word.cmd == CMD_QUERY))
                begin
                    px_next    = in_word.pos_x;
                    pz_next    = in_word.pos_z;
                    state_next = S_CHKX;
                end
            end
            S_CHKX:
            begin
                if ({12'd0, px_reg} > $unsigned(prod))
                begin
                    res_next.height_out = '0;
                    res_next.outside    = 1'b1;
                    state_next          = S_FIN;
                end
                else
                    state_next = S_CHKZ;
            end
            S_CHKZ:
            begin
                if ({12'd0, pz_reg} > $unsigned(prod))
                begin
                    res_next.height_out = '0;
                    res_next.outside    = 1'b1;
                    state_next          = S_FIN;
                end
                else
                begin
                    rem_next   = REM_W'(px_reg);
                    dsh_next   = REM_W'(iv_eff) << (CELL_W - 1);
                    quot_next  = '0;
                    cnt_next   = CNT_W'(CELL_W - 1);
                    state_next = S_DIVX;
                end
            end
            S_DIVX, S_DIVZ:
            begin
                rem_next  = rem_step;
                dsh_next  = dsh_reg >> 1;
                quot_next = quot_step;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    // A position on the far grid line lands in the last cell.
                    if (state_reg == S_DIVX)
                    begin
                        if (q_cell == w_eff)
                        begin
                            cx_next = w_eff - CELL_W'(1);
                            fx_next = iv_eff;
                        end
                        else
                        begin
                            cx_next = q_cell;
                            fx_next = rem_step[IVL_W-1:0];
                        end
                        rem_next   = REM_W'(pz_reg);
                        dsh_next   = REM_W'(iv_eff) << (CELL_W - 1);
                        quot_next  = '0;
                        cnt_next   = CNT_W'(CELL_W - 1);
                        state_next = S_DIVZ;
                    end
                    else
                    begin
                        if (q_cell == d_eff)
                        begin
                            cz_next = d_eff - CELL_W'(1);
                            fz_next = iv_eff;
                        end
                        else
                        begin
                            cz_next = q_cell;
                            fz_next = rem_step[IVL_W-1:0];
                        end
                        state_next = S_RD0;
                    end
                end
            end
            S_RD0:
            begin
                lower_next = ({1'b0, fx_reg} + {1'b0, fz_reg}) < {1'b0, iv_eff};
                state_next = S_RD1;
            end
            S_RD1:
            begin
                h10_next   = mem_q;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                h01_next   = mem_q;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                base_next  = mem_q;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                num_next   = prod;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                num_next   = num_reg + prod;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                rem_next   = n_off[REM_W-1:0];
                dsh_next   = REM_W'(iv_eff) << (H_SH + 1);
                quot_next  = '0;
                cnt_next   = CNT_W'(QUOT_W - 1);
                state_next = S_DIVH;
            end
            S_DIVH:
            begin
                rem_next  = rem_step;
                dsh_next  = dsh_reg >> 1;
                quot_next = quot_step;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    res_next.height_out = h_sat;
                    res_next.outside    = 1'b0;
                    state_next          = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= COORD_W'(GRID_MAX);
            depth_reg     <= COORD_W'(GRID_MAX);
            ivl_reg       <= IVL_W'(256);
            px_reg        <= '0;
            pz_reg        <= '0;
            cx_reg        <= '0;
            cz_reg        <= '0;
            fx_reg        <= '0;
            fz_reg        <= '0;
            lower_reg     <= 1'b0;
            h10_reg       <= '0;
            h01_reg       <= '0;
            base_reg      <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            dsh_reg       <= '0;
            quot_reg      <= '0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            depth_reg     <= depth_next;
            ivl_reg       <= ivl_next;
            px_reg        <= px_next;
            pz_reg        <= pz_next;
            cx_reg        <= cx_next;
            cz_reg        <= cz_next;
            fx_reg        <= fx_next;
            fz_reg        <= fz_next;
            lower_reg     <= lower_next;
            h10_reg       <= h10_next;
            h01_reg       <= h01_next;
            base_reg      <= base_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            dsh_reg       <= dsh_next;
            quot_reg      <= quot_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

`ifndef SYNTHESIS
    // An outside result always carries a zero height.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.outside |-> out_word.height_out == '0)
        else $error("outside result with nonzero height");

    // A write word never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.cmd == CMD_WRITE && !out_valid |=> !out_valid)
        else $error("write word produced a result");

    // After the cell search the cell lies inside the grid and the offsets
    // stay within one interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD0 |-> cx_reg < w_eff && cz_reg < d_eff
                               && fx_reg <= iv_eff && fz_reg <= iv_eff)
        else $error("cell index or offset out of range");
`endif

endmodule

`default_nettype wire
